// ===== rtl/flvd_pkg.sv =====
// ----------------------------------------------------------------------------
// flvd_pkg
// Shared types and constants for the FLV tag deframer.
// ----------------------------------------------------------------------------
package flvd_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 25;
    localparam int NIB_W   = 4;

    // unit header layout
    localparam logic [BYTE_W-1:0]  SIG_F         = 8'h46;
    localparam logic [BYTE_W-1:0]  SIG_L         = 8'h4C;
    localparam logic [BYTE_W-1:0]  SIG_V         = 8'h56;
    localparam logic [BYTE_W-1:0]  TYPE_VIDEO    = 8'h09;
    localparam logic [NIB_W-1:0]   FRAME_KEY     = 4'h1;
    localparam logic [COUNT_W-1:0] UNIT_HDR_LEN  = 25'd11;
    localparam logic [COUNT_W-1:0] FILE_HDR_LAST = 25'd12;
    localparam logic [COUNT_W-1:0] TAG_OVERHEAD  = 25'd15;
    localparam logic [COUNT_W-1:0] FRAME_BYTE    = 25'd11;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_COLLECT = 2'd0,
        PH_FILEHDR = 2'd1,
        PH_TAG     = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_out;
        logic               in_file_header;
        logic               tag_first;
        logic               tag_last;
        logic               is_keyframe;
        logic [COUNT_W-1:0] tag_length;
        logic               stream_error;
    } t_result;

endpackage

// ===== rtl/flvd_classify.sv =====
// ----------------------------------------------------------------------------
// flvd_classify
// Front end: takes one stream byte per transfer, tracks unit framing and
// builds the marked result for that byte.
// ----------------------------------------------------------------------------
module flvd_classify import flvd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_full,
    output logic              o_push,
    output t_result           o_result
);

    t_phase             r_phase,  n_phase;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic [COUNT_W-1:0] r_total,  n_total;
    logic               r_sig,    n_sig;
    logic               r_hdr_ok, n_hdr_ok;
    logic [BYTE_W-1:0]  r_kind,   n_kind;
    logic [NIB_W-1:0]   r_nib,    n_nib;
    logic               r_err,    n_err;

    logic [COUNT_W-1:0] cidx;
    logic [COUNT_W:0]   next_idx;

    assign o_push = i_valid && !i_full;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_total  = r_total;
        n_sig    = r_sig;
        n_hdr_ok = r_hdr_ok;
        n_kind   = r_kind;
        n_nib    = r_nib;
        n_err    = r_err;
        o_result = '0;
        o_result.byte_out = i_data_byte;
        cidx     = (r_phase == PH_COLLECT) ? r_count : '0;
        next_idx = {1'b0, r_count} + 1'b1;

        if (r_err) begin
            o_result.stream_error = 1'b1;
        end else begin
            case (r_phase)
                PH_FILEHDR: begin
                    o_result.in_file_header = 1'b1;
                    if (i_data_byte != '0) n_hdr_ok = 1'b0;
                    if (r_count >= FILE_HDR_LAST) begin
                        if (n_hdr_ok) begin
                            n_phase = PH_COLLECT;
                            n_count = '0;
                        end else begin
                            n_err = 1'b1;
                            o_result.stream_error = 1'b1;
                        end
                    end else begin
                        n_count = next_idx[COUNT_W-1:0];
                    end
                end
                PH_TAG: begin
                    o_result.tag_length = r_total;
                    if (r_count == FRAME_BYTE) n_nib = i_data_byte[BYTE_W-1 -: NIB_W];
                    if (next_idx >= {1'b0, r_total}) begin
                        o_result.tag_last    = 1'b1;
                        o_result.is_keyframe = (r_kind == TYPE_VIDEO) && (n_nib == FRAME_KEY);
                        n_phase = PH_COLLECT;
                        n_count = '0;
                    end else begin
                        n_count = next_idx[COUNT_W-1:0];
                    end
                end
                default: begin
                    // unit header; an unknown phase code restarts at byte 0
                    n_phase = PH_COLLECT;
                    case (cidx)
                        25'd0: begin
                            n_sig    = (i_data_byte == SIG_F);
                            n_hdr_ok = 1'b1;
                            n_kind   = i_data_byte;
                            n_total  = '0;
                            o_result.tag_first = (i_data_byte != SIG_F);
                        end
                        25'd1: begin
                            if (i_data_byte != SIG_L) n_sig = 1'b0;
                            n_total = {1'b0, i_data_byte, 16'h0000};
                        end
                        25'd2: begin
                            if (i_data_byte != SIG_V) n_sig = 1'b0;
                            n_total = r_total | {9'h000, i_data_byte, 8'h00};
                        end
                        25'd3: begin
                            n_total = (r_total | {17'h00000, i_data_byte}) + TAG_OVERHEAD;
                        end
                        25'd8: begin
                            if (i_data_byte != TYPE_VIDEO) n_hdr_ok = 1'b0;
                        end
                        25'd9, 25'd10: begin
                            if (i_data_byte != '0) n_hdr_ok = 1'b0;
                        end
                        default: begin
                        end
                    endcase

                    if (n_sig) begin
                        o_result.in_file_header = 1'b1;
                    end else if (cidx >= 25'd3) begin
                        o_result.tag_length = n_total;
                    end

                    n_count = cidx + 1'b1;
                    if (n_count >= UNIT_HDR_LEN) begin
                        n_phase = n_sig ? PH_FILEHDR : PH_TAG;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_COLLECT;
            r_count  <= '0;
            r_total  <= '0;
            r_sig    <= 1'b1;
            r_hdr_ok <= 1'b1;
            r_kind   <= '0;
            r_nib    <= '0;
            r_err    <= 1'b0;
        end else if (o_push) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_total  <= n_total;
            r_sig    <= n_sig;
            r_hdr_ok <= n_hdr_ok;
            r_kind   <= n_kind;
            r_nib    <= n_nib;
            r_err    <= n_err;
        end
    end

endmodule

// ===== rtl/flvd_queue.sv =====
// ----------------------------------------------------------------------------
// flvd_queue
// Back end: short result queue that drives the output channel and lets the
// front keep taking bytes while the sink stalls, until the queue is full.
// ----------------------------------------------------------------------------
module flvd_queue import flvd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_item,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_item
);

    t_result            r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign pop     = o_valid && !i_stall;
    assign o_item  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (pop)    r_rd <= r_rd + 1'b1;
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/flv_tag_deframer.sv =====
// ----------------------------------------------------------------------------
// flv_tag_deframer
// Marks the framing of an FLV byte stream: file header, tag bounds, tag
// length, keyframe and a sticky header error on every byte.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  input   | i_valid / o_stall  | i_data_byte
//  output  | o_valid / i_stall  | o_byte_out, o_in_file_header, o_tag_first,
//          |                    | o_tag_last, o_is_keyframe, o_tag_length,
//          |                    | o_stream_error
//
// One byte per cycle while o_stall is low; with the queue empty, a result is
// offered in the cycle after its byte transfer.
// The front registers the framing state on each byte transfer; a 4-entry result
// queue sits between front and output.
// o_stall rises only while the queue holds 4 results.
// Synchronous reset clears the framing state and empties the queue.
// ----------------------------------------------------------------------------
module flv_tag_deframer import flvd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [BYTE_W-1:0]  i_data_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [BYTE_W-1:0]  o_byte_out,
    output logic               o_in_file_header,
    output logic               o_tag_first,
    output logic               o_tag_last,
    output logic               o_is_keyframe,
    output logic [COUNT_W-1:0] o_tag_length,
    output logic               o_stream_error
);

    logic    push;
    logic    full;
    t_result front_res;
    t_result back_res;

    flvd_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_full      (full),
        .o_push      (push),
        .o_result    (front_res)
    );

    flvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_res),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (back_res)
    );

    assign o_stall          = full;
    assign o_byte_out       = back_res.byte_out;
    assign o_in_file_header = back_res.in_file_header;
    assign o_tag_first      = back_res.tag_first;
    assign o_tag_last       = back_res.tag_last;
    assign o_is_keyframe    = back_res.is_keyframe;
    assign o_tag_length     = back_res.tag_length;
    assign o_stream_error   = back_res.stream_error;

    a_first_last_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_tag_first && o_tag_last))
        else $error("tag_first and tag_last on the same byte");

    a_key_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_keyframe) |-> o_tag_last)
        else $error("keyframe flag outside a tag's last byte");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_stream_error) ##1 o_valid |-> o_stream_error)
        else $error("stream error dropped after it was raised");

    a_stall_when_backed_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

endmodule

// ===== bench/flv_tag_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_tag_deframer_tb
// Self-checking bench for the FLV tag deframer. A directed table opens with a
// clean file header and a tag whose type byte is 'F'. Random file headers and
// tags with random content follow. The run closes on a broken file header
// that latches the sticky error. Every output transfer is compared field by
// field against its typed table row, else a cycle-free model of framing state.
// ----------------------------------------------------------------------------
module flv_tag_deframer_tb;
    import flvd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int IDLE_PCT     = 8;
    localparam int QUIET_START  = 450;
    localparam int QUIET_END    = 650;
    localparam int HOLD_START   = 300;
    localparam int HOLD_LEN     = 40;
    localparam int DRAIN_CYCLES = 20;
    localparam int PLAN_BYTES   = 520;

    // flags are {in_file_header, tag_first, tag_last, is_keyframe}
    typedef struct packed {
        logic [BYTE_W-1:0]  b;
        logic               typed;
        logic [3:0]         flags;
        logic [COUNT_W-1:0] len;
        logic               err;
    } t_row;

    localparam int N_ROWS = 28;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // file header: signature, version, flags, header size 9, zero pointer
        '{8'h46, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h4C, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h56, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'hFF, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h05, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h09, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b1000, 25'd0,  1'b0},
        // empty tag of type 'F': looks like a signature until its second byte
        '{8'h46, 1'b1, 4'b1000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b0000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b0000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b0000, 25'd15, 1'b0},
        '{8'hFF, 1'b0, 4'b0000, 25'd0,  1'b0},
        '{8'hFF, 1'b0, 4'b0000, 25'd0,  1'b0},
        '{8'hFF, 1'b0, 4'b0000, 25'd0,  1'b0},
        '{8'hFF, 1'b0, 4'b0000, 25'd0,  1'b0},
        '{8'h00, 1'b1, 4'b0000, 25'd15, 1'b0},
        '{8'h00, 1'b1, 4'b0000, 25'd15, 1'b0},
        '{8'h00, 1'b1, 4'b0000, 25'd15, 1'b0},
        '{8'h00, 1'b1, 4'b0000, 25'd15, 1'b0},
        '{8'h00, 1'b0, 4'b0000, 25'd0,  1'b0},
        '{8'h00, 1'b0, 4'b0000, 25'd0,  1'b0},
        '{8'h0B, 1'b1, 4'b0010, 25'd15, 1'b0}
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [BYTE_W-1:0]  i_data_byte = '0;
    logic               i_stall     = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [BYTE_W-1:0]  o_byte_out;
    logic               o_in_file_header;
    logic               o_tag_first;
    logic               o_tag_last;
    logic               o_is_keyframe;
    logic [COUNT_W-1:0] o_tag_length;
    logic               o_stream_error;

    int                cyc = 0;
    int                rx_cycles = 0;
    int                mismatches = 0;
    t_result           marks_due [$];
    logic [BYTE_W-1:0] stream_plan [$];

    // framing state of the model
    t_phase             fr_phase  = PH_COLLECT;
    logic [COUNT_W-1:0] fr_count  = '0;
    logic [COUNT_W-1:0] fr_total  = '0;
    logic               fr_sig    = 1'b1;
    logic               fr_hdr_ok = 1'b1;
    logic [BYTE_W-1:0]  fr_kind   = '0;
    logic [NIB_W-1:0]   fr_nib    = '0;
    logic               fr_err    = 1'b0;

    flv_tag_deframer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_byte_out       (o_byte_out),
        .o_in_file_header (o_in_file_header),
        .o_tag_first      (o_tag_first),
        .o_tag_last       (o_tag_last),
        .o_is_keyframe    (o_is_keyframe),
        .o_tag_length     (o_tag_length),
        .o_stream_error   (o_stream_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYCLES) begin
            $display("flv_tag_deframer regression: fail");
            $finish;
        end
    end

    function automatic bit quiet_window();
        return cyc >= QUIET_START && cyc < QUIET_END;
    endfunction

    // Advance the framing state by one byte and return its marks.
    function automatic t_result mark_byte(input logic [BYTE_W-1:0] b);
        t_result            r;
        logic [COUNT_W-1:0] idx;
        r          = '0;
        r.byte_out = b;
        idx        = fr_count;
        if (fr_err) begin
            r.stream_error = 1'b1;
            return r;
        end
        if (fr_phase == PH_FILEHDR) begin
            r.in_file_header = 1'b1;
            if (b != '0)
                fr_hdr_ok = 1'b0;
            if (idx >= FILE_HDR_LAST) begin
                if (fr_hdr_ok) begin
                    fr_phase = PH_COLLECT;
                    fr_count = '0;
                end else begin
                    fr_err         = 1'b1;
                    r.stream_error = 1'b1;
                end
            end else begin
                fr_count = idx + 1'b1;
            end
            return r;
        end
        if (fr_phase == PH_TAG) begin
            r.tag_length = fr_total;
            if (idx == FRAME_BYTE)
                fr_nib = b[7:4];
            if (idx + 1 >= fr_total) begin
                r.tag_last    = 1'b1;
                r.is_keyframe = (fr_kind == TYPE_VIDEO) && (fr_nib == FRAME_KEY);
                fr_phase      = PH_COLLECT;
                fr_count      = '0;
            end else begin
                fr_count = idx + 1'b1;
            end
            return r;
        end
        // unused phase code restarts the unit header
        if (fr_phase != PH_COLLECT) begin
            fr_phase = PH_COLLECT;
            idx      = '0;
        end
        case (idx)
            0: begin
                fr_sig      = (b == SIG_F);
                fr_hdr_ok   = 1'b1;
                fr_kind     = b;
                fr_total    = '0;
                r.tag_first = !fr_sig;
            end
            1: begin
                if (b != SIG_L)
                    fr_sig = 1'b0;
                fr_total = {1'b0, b, 16'h0000};
            end
            2: begin
                if (b != SIG_V)
                    fr_sig = 1'b0;
                fr_total = fr_total | {9'h000, b, 8'h00};
            end
            3: fr_total = (fr_total | {17'h00000, b}) + TAG_OVERHEAD;
            8: if (b != TYPE_VIDEO) fr_hdr_ok = 1'b0;
            9, 10: if (b != '0) fr_hdr_ok = 1'b0;
            default: ;
        endcase
        if (fr_sig)
            r.in_file_header = 1'b1;
        else if (idx >= 3)
            r.tag_length = fr_total;
        fr_count = idx + 1'b1;
        if (fr_count >= UNIT_HDR_LEN)
            fr_phase = fr_sig ? PH_FILEHDR : PH_TAG;
        return r;
    endfunction

    function automatic void plan_file_header(input int bad_pos);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < 13; i++) begin
            case (i)
                0: b = SIG_F;
                1: b = SIG_L;
                2: b = SIG_V;
                8: b = TYPE_VIDEO;
                3, 4, 5, 6, 7: b = BYTE_W'($urandom_range(255));
                default: b = '0;
            endcase
            if (i == bad_pos)
                b = (i == 8) ? (b ^ BYTE_W'($urandom_range(1, 255)))
                             : BYTE_W'($urandom_range(1, 255));
            stream_plan.push_back(b);
        end
    endfunction

    function automatic void plan_tag(input logic [BYTE_W-1:0] kind, input int size,
                                     input bit key);
        logic [23:0]       sz;
        logic [BYTE_W-1:0] b;
        sz = 24'(size);
        for (int i = 0; i < size + 15; i++) begin
            b = BYTE_W'($urandom_range(255));
            case (i)
                0: b = kind;
                1: b = sz[23:16];
                2: b = sz[15:8];
                3: b = sz[7:0];
                11: if (key) b[7:4] = FRAME_KEY;
                default: ;
            endcase
            stream_plan.push_back(b);
        end
    endfunction

    task automatic transfer_byte(input logic [BYTE_W-1:0] b, output t_result marks);
        while (!quiet_window() && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        marks = mark_byte(b);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // receiver: random stall, one long hold-off, one stretch without stall
    always @(posedge i_clk) begin
        if (i_rst_n)
            rx_cycles <= rx_cycles + 1;
        if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN)
            i_stall <= 1'b1;
        else if (quiet_window())
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (marks_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: byte 0x%0h transferred, expected no result, actual one",
                         $time, o_byte_out);
            end else begin
                want = marks_due.pop_front();
                check_field("byte_out",       32'(want.byte_out),       32'(o_byte_out));
                check_field("in_file_header", 32'(want.in_file_header),
                            32'(o_in_file_header));
                check_field("tag_first",      32'(want.tag_first),      32'(o_tag_first));
                check_field("tag_last",       32'(want.tag_last),       32'(o_tag_last));
                check_field("is_keyframe",    32'(want.is_keyframe),    32'(o_is_keyframe));
                check_field("tag_length",     32'(want.tag_length),     32'(o_tag_length));
                check_field("stream_error",   32'(want.stream_error),   32'(o_stream_error));
            end
        end
    end

    initial begin : stimulus
        t_result           marks;
        t_result           typed_marks;
        logic [BYTE_W-1:0] kind;
        int                pick;
        int                size;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_ROWS; n++) begin
            transfer_byte(DIRECTED_ROWS[n].b, marks);
            if (DIRECTED_ROWS[n].typed) begin
                typed_marks                = '0;
                typed_marks.byte_out       = DIRECTED_ROWS[n].b;
                {typed_marks.in_file_header, typed_marks.tag_first,
                 typed_marks.tag_last, typed_marks.is_keyframe} = DIRECTED_ROWS[n].flags;
                typed_marks.tag_length     = DIRECTED_ROWS[n].len;
                typed_marks.stream_error   = DIRECTED_ROWS[n].err;
                marks_due.push_back(typed_marks);
            end else begin
                marks_due.push_back(marks);
            end
        end

        // hold until the directed results are all in
        i_valid <= 1'b0;
        while (marks_due.size() != 0)
            @(posedge i_clk);

        while (stream_plan.size() < PLAN_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                plan_file_header(-1);
            end else begin
                pick = $urandom_range(99);
                if (pick < 40)      kind = TYPE_VIDEO;
                else if (pick < 60) kind = 8'h08;
                else if (pick < 70) kind = 8'h12;
                else if (pick < 80) kind = SIG_F;
                else                kind = BYTE_W'($urandom_range(255));
                size = ($urandom_range(99) < 85) ? $urandom_range(24) : $urandom_range(25, 400);
                plan_tag(kind, size, 1'($urandom_range(1)));
            end
        end
        // close on a broken file header, then bytes under the latched error
        plan_file_header($urandom_range(8, 12));
        repeat (8) stream_plan.push_back(BYTE_W'($urandom_range(255)));

        while (stream_plan.size() != 0) begin
            transfer_byte(stream_plan.pop_front(), marks);
            marks_due.push_back(marks);
        end
        i_valid <= 1'b0;

        while (marks_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("flv_tag_deframer regression: pass");
        else
            $display("flv_tag_deframer regression: fail");
        $finish;
    end

endmodule
